@@ src/rscp_pkg.sv @@
package rscp_pkg;

    localparam int FRAME_LIMIT = 64;
    localparam int POS_W       = $clog2(FRAME_LIMIT + 2);
    localparam int CHAR_W      = 8;
    localparam int SPD_W       = 16;
    localparam int EVENT_W     = 4;
    localparam int CFG_IDX_W   = 8;

    // register indexes of the configuration port
    localparam logic [CFG_IDX_W-1:0] REG_CODE_ECHO      = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CODE_STATUS    = 8'd1;
    localparam logic [CFG_IDX_W-1:0] REG_CODE_SET_MOTOR = 8'd2;
    localparam logic [CFG_IDX_W-1:0] REG_CODE_SET_AUTO  = 8'd3;

    typedef enum logic [EVENT_W-1:0] {
        EV_NONE      = 4'd0,
        EV_ECHO      = 4'd1,
        EV_STATUS    = 4'd2,
        EV_SET_MOTOR = 4'd3,
        EV_SET_AUTO  = 4'd4,
        EV_UNKNOWN   = 4'd5,
        EV_BINARY    = 4'd6,
        EV_KILL      = 4'd7,
        EV_STOP      = 4'd8,
        EV_FWD       = 4'd9,
        EV_BACK      = 4'd10,
        EV_LEFT      = 4'd11,
        EV_RIGHT     = 4'd12
    } t_event;

    typedef enum logic [3:0] {
        OP_NONE      = 4'd0,
        OP_KILL      = 4'd1,
        OP_STOP      = 4'd2,
        OP_FWD       = 4'd3,
        OP_BACK      = 4'd4,
        OP_LEFT      = 4'd5,
        OP_RIGHT     = 4'd6,
        OP_SET_MOTOR = 4'd7,
        OP_SET_AUTO  = 4'd8
    } t_drive_op;

    // bit 0 right, bit 1 left, bit 2 mode
    typedef struct packed {
        t_drive_op               op;
        logic signed [SPD_W-1:0] right;
        logic signed [SPD_W-1:0] left;
        logic signed [SPD_W-1:0] mode;
        logic [2:0]              present;
    } t_drive_cmd;

endpackage

@@ src/rscp_if.sv @@
interface rscp_byte_if;
    import rscp_pkg::*;
    logic              valid;
    logic              ready;
    logic [CHAR_W-1:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

interface rscp_res_if;
    import rscp_pkg::*;
    logic                    valid;
    logic                    ready;
    logic signed [SPD_W-1:0] speed_right;
    logic signed [SPD_W-1:0] speed_left;
    logic signed [SPD_W-1:0] auto_mode;
    logic                    stopped;
    logic [EVENT_W-1:0]      event_res;

    modport source (output valid, output speed_right, output speed_left, output auto_mode,
                    output stopped, output event_res, input ready);
    modport sink   (input valid, input speed_right, input speed_left, input auto_mode,
                    input stopped, input event_res, output ready);
endinterface

interface rscp_cfg_if;
    import rscp_pkg::*;
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [CHAR_W-1:0]    data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

@@ src/robot_serial_command_parser.sv @@
// Serial command parser for a small drive base. One received byte is taken per clock and
// answered by exactly one result item in the next cycle: the drive state after that byte
// (right and left speed, mode, stop flag) and an event code. The result sits in an output
// register; a new byte is accepted whenever that register is empty or is being taken in the
// same cycle, so a steady stream runs at one byte per clock. Frames open with "<@ " (text)
// or "<! " (binary); text frames close on '>' and are dispatched on their command character,
// binary frames close on the byte after the position reaches the length byte. Outside a
// frame, single keys act on the drive at once. The four command characters are written
// through the configuration port, which is always ready; write it only while the block is idle.
module robot_serial_command_parser (
    input  logic               i_clk,
    input  logic               i_rst_n,
    rscp_byte_if.sink          i_rx,
    rscp_res_if.source         o_res,
    rscp_cfg_if.sink           i_cfg
);
    import rscp_pkg::*;

    typedef enum logic [2:0] {
        PH_LEAD  = 3'b001,
        PH_DIGIT = 3'b010,
        PH_HALT  = 3'b100
    } t_phase;

    localparam logic [CHAR_W-1:0] CH_LT    = 8'h3C;
    localparam logic [CHAR_W-1:0] CH_GT    = 8'h3E;
    localparam logic [CHAR_W-1:0] CH_AT    = 8'h40;
    localparam logic [CHAR_W-1:0] CH_BANG  = 8'h21;
    localparam logic [CHAR_W-1:0] CH_SP    = 8'h20;
    localparam logic [CHAR_W-1:0] CH_PLUS  = 8'h2B;
    localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;
    localparam logic [CHAR_W-1:0] CH_0     = 8'h30;
    localparam logic [CHAR_W-1:0] CH_9     = 8'h39;
    localparam logic [CHAR_W-1:0] CH_TAB   = 8'h09;
    localparam logic [CHAR_W-1:0] CH_CR    = 8'h0D;
    localparam logic [CHAR_W-1:0] KEY_KILL  = 8'h6B;
    localparam logic [CHAR_W-1:0] KEY_STOP  = 8'h76;
    localparam logic [CHAR_W-1:0] KEY_FWD   = 8'h77;
    localparam logic [CHAR_W-1:0] KEY_BACK  = 8'h73;
    localparam logic [CHAR_W-1:0] KEY_LEFT  = 8'h61;
    localparam logic [CHAR_W-1:0] KEY_RIGHT = 8'h64;

    localparam int               ACC_W   = SPD_W;
    localparam int               PROD_W  = ACC_W + 4;
    localparam logic [ACC_W-1:0] ACC_SAT = 16'd32768;
    localparam logic [ACC_W-1:0] POS_MAX = 16'd32767;
    localparam logic [2:0]       TOK_MAX = 3'd7;
    localparam logic [2:0]       TOK_RIGHT = 3'd2;
    localparam logic [2:0]       TOK_LEFT  = 3'd3;
    localparam logic [2:0]       TOK_MODE  = 3'd4;

    // configuration
    logic [CHAR_W-1:0] r_code_echo, r_code_status, r_code_motor, r_code_auto;

    // framing and token state
    logic [POS_W-1:0]        r_pos, n_pos;
    logic                    r_bin, n_bin;
    logic [CHAR_W-1:0]       r_cmd, n_cmd;
    logic [2:0]              r_tok, n_tok;
    logic                    r_in_tok, n_in_tok;
    logic [ACC_W-1:0]        r_acc, n_acc;
    logic                    r_neg, n_neg;
    t_phase                  r_phase, n_phase;
    logic signed [SPD_W-1:0] r_pend_r, n_pend_r;
    logic signed [SPD_W-1:0] r_pend_l, n_pend_l;
    logic signed [SPD_W-1:0] r_pend_m, n_pend_m;
    logic [2:0]              r_pv, n_pv;

    // result slot
    logic                    r_out_valid;
    t_event                  r_event, n_event;

    logic                    in_rdy, in_acc;
    logic [CHAR_W-1:0]       c;
    t_drive_op               op;
    t_drive_cmd              drv_cmd;

    // token close preview
    logic signed [SPD_W-1:0] cl_val;
    logic [2:0]              cl_idx;
    logic signed [SPD_W-1:0] cl_r, cl_l, cl_m;
    logic [2:0]              cl_pv;

    // token feed preview
    logic [2:0]              f_tok;
    logic [ACC_W-1:0]        f_acc;
    logic                    f_neg;
    t_phase                  f_phase;
    logic [ACC_W-1:0]        st_acc;
    logic                    st_neg;
    t_phase                  st_phase;
    logic                    is_ws, is_sign, is_digit, do_digit;
    logic [PROD_W-1:0]       prod;

    assign c      = i_rx.rx_byte;
    assign in_rdy = !r_out_valid || o_res.ready;
    assign in_acc = i_rx.valid && in_rdy;

    assign i_rx.ready  = in_rdy;
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_code_echo   <= 8'h45;
            r_code_status <= 8'h53;
            r_code_motor  <= 8'h4D;
            r_code_auto   <= 8'h41;
        end else if (i_cfg.valid) begin
            unique case (i_cfg.index)
                REG_CODE_ECHO:      r_code_echo   <= i_cfg.data;
                REG_CODE_STATUS:    r_code_status <= i_cfg.data;
                REG_CODE_SET_MOTOR: r_code_motor  <= i_cfg.data;
                REG_CODE_SET_AUTO:  r_code_auto   <= i_cfg.data;
                default: begin
                end
            endcase
        end
    end

    // close the open token into its pending slot
    always_comb begin
        cl_val = r_neg ? SPD_W'(~r_acc + 1'b1)
                       : ((r_acc > POS_MAX) ? POS_MAX : r_acc);
        cl_idx = r_tok - 3'd1;
        cl_r   = r_pend_r;
        cl_l   = r_pend_l;
        cl_m   = r_pend_m;
        cl_pv  = r_pv;
        if (r_in_tok) begin
            if (cl_idx == TOK_RIGHT) begin
                cl_r     = cl_val;
                cl_pv[0] = 1'b1;
            end else if (cl_idx == TOK_LEFT) begin
                cl_l     = cl_val;
                cl_pv[1] = 1'b1;
            end else if (cl_idx == TOK_MODE) begin
                cl_m     = cl_val;
                cl_pv[2] = 1'b1;
            end
        end
    end

    // feed one character into the number being read
    always_comb begin
        is_ws    = (c >= CH_TAB) && (c <= CH_CR);
        is_sign  = (c == CH_PLUS) || (c == CH_MINUS);
        is_digit = (c >= CH_0) && (c <= CH_9);
        if (!r_in_tok) begin
            st_acc   = '0;
            st_neg   = 1'b0;
            st_phase = PH_LEAD;
            f_tok    = (r_tok < TOK_MAX) ? r_tok + 3'd1 : r_tok;
        end else begin
            st_acc   = r_acc;
            st_neg   = r_neg;
            st_phase = r_phase;
            f_tok    = r_tok;
        end
        f_acc    = st_acc;
        f_neg    = st_neg;
        f_phase  = st_phase;
        do_digit = (st_phase == PH_DIGIT) || ((st_phase == PH_LEAD) && !is_ws && !is_sign);
        prod     = PROD_W'(st_acc) * PROD_W'(10) + PROD_W'(c - CH_0);
        if ((st_phase == PH_LEAD) && is_sign) begin
            f_neg   = (c == CH_MINUS);
            f_phase = PH_DIGIT;
        end else if (do_digit) begin
            if (is_digit) begin
                f_phase = PH_DIGIT;
                f_acc   = (prod > PROD_W'(ACC_SAT)) ? ACC_SAT : ACC_W'(prod);
            end else begin
                f_phase = PH_HALT;
            end
        end
    end

    always_comb begin
        n_pos    = r_pos;
        n_bin    = r_bin;
        n_cmd    = r_cmd;
        n_tok    = r_tok;
        n_in_tok = r_in_tok;
        n_acc    = r_acc;
        n_neg    = r_neg;
        n_phase  = r_phase;
        n_pend_r = r_pend_r;
        n_pend_l = r_pend_l;
        n_pend_m = r_pend_m;
        n_pv     = r_pv;
        n_event  = EV_NONE;
        op       = OP_NONE;
        priority if (r_pos == '0 && c == CH_LT) begin
            n_pos = POS_W'(1);
        end else if (r_pos == POS_W'(1)) begin
            if (c == CH_AT || c == CH_BANG) begin
                n_bin = (c == CH_BANG);
                n_pos = POS_W'(2);
            end else begin
                n_pos = '0;
                n_bin = 1'b0;
                n_cmd = '0;
            end
        end else if (r_pos == POS_W'(2)) begin
            if (c == CH_SP) begin
                n_pos    = POS_W'(3);
                n_tok    = 3'd1;
                n_in_tok = 1'b0;
                n_pv     = '0;
                n_acc    = '0;
                n_neg    = 1'b0;
                n_phase  = PH_LEAD;
            end else begin
                n_pos = '0;
                n_bin = 1'b0;
                n_cmd = '0;
            end
        end else if (r_pos > POS_W'(FRAME_LIMIT)) begin
            // overflow: drop the frame, a '<' reopens one
            n_pos = (c == CH_LT) ? POS_W'(1) : '0;
            n_bin = 1'b0;
            n_cmd = '0;
        end else if (r_pos > POS_W'(2)) begin
            if (!r_bin && c == CH_GT) begin
                n_in_tok = 1'b0;
                n_pend_r = cl_r;
                n_pend_l = cl_l;
                n_pend_m = cl_m;
                n_pv     = cl_pv;
                priority if (r_pos == POS_W'(3)) begin
                    n_event = EV_UNKNOWN;
                end else if (r_cmd == r_code_echo) begin
                    n_event = EV_ECHO;
                end else if (r_cmd == r_code_status) begin
                    n_event = EV_STATUS;
                end else if (r_cmd == r_code_motor) begin
                    n_event = EV_SET_MOTOR;
                    op      = OP_SET_MOTOR;
                end else if (r_cmd == r_code_auto) begin
                    n_event = EV_SET_AUTO;
                    op      = OP_SET_AUTO;
                end else begin
                    n_event = EV_UNKNOWN;
                end
                n_pos = '0;
                n_bin = 1'b0;
                n_cmd = '0;
            end else if (r_bin && r_pos > POS_W'(3)
                         && (9'(r_pos) == 9'(r_cmd))) begin
                n_event = EV_BINARY;
                n_pos   = '0;
                n_bin   = 1'b0;
                n_cmd   = '0;
            end else begin
                if (r_pos == POS_W'(3)) begin
                    n_cmd = c;
                end
                if (!r_bin) begin
                    if (c == CH_SP) begin
                        n_in_tok = 1'b0;
                        n_pend_r = cl_r;
                        n_pend_l = cl_l;
                        n_pend_m = cl_m;
                        n_pv     = cl_pv;
                    end else begin
                        n_in_tok = 1'b1;
                        n_tok    = f_tok;
                        n_acc    = f_acc;
                        n_neg    = f_neg;
                        n_phase  = f_phase;
                    end
                end
                n_pos = POS_W'(r_pos + 1'b1);
            end
        end else begin
            unique case (c)
                KEY_KILL: begin
                    n_event = EV_KILL;
                    op      = OP_KILL;
                end
                KEY_STOP: begin
                    n_event = EV_STOP;
                    op      = OP_STOP;
                end
                KEY_FWD: begin
                    n_event = EV_FWD;
                    op      = OP_FWD;
                end
                KEY_BACK: begin
                    n_event = EV_BACK;
                    op      = OP_BACK;
                end
                KEY_LEFT: begin
                    n_event = EV_LEFT;
                    op      = OP_LEFT;
                end
                KEY_RIGHT: begin
                    n_event = EV_RIGHT;
                    op      = OP_RIGHT;
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos       <= '0;
            r_bin       <= 1'b0;
            r_cmd       <= '0;
            r_tok       <= '0;
            r_in_tok    <= 1'b0;
            r_acc       <= '0;
            r_neg       <= 1'b0;
            r_phase     <= PH_LEAD;
            r_pv        <= '0;
            r_event     <= EV_NONE;
            r_out_valid <= 1'b0;
        end else begin
            if (in_acc) begin
                r_pos    <= n_pos;
                r_bin    <= n_bin;
                r_cmd    <= n_cmd;
                r_tok    <= n_tok;
                r_in_tok <= n_in_tok;
                r_acc    <= n_acc;
                r_neg    <= n_neg;
                r_phase  <= n_phase;
                r_pv     <= n_pv;
                r_event  <= n_event;
            end
            if (in_acc) begin
                r_out_valid <= 1'b1;
            end else if (o_res.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend_r <= '0;
            r_pend_l <= '0;
            r_pend_m <= '0;
        end else if (in_acc) begin
            r_pend_r <= n_pend_r;
            r_pend_l <= n_pend_l;
            r_pend_m <= n_pend_m;
        end
    end

    // drive state changes only with an accepted item, so it doubles as the result payload
    always_comb begin
        drv_cmd.op      = in_acc ? op : OP_NONE;
        drv_cmd.right   = cl_r;
        drv_cmd.left    = cl_l;
        drv_cmd.mode    = cl_m;
        drv_cmd.present = cl_pv;
    end

    rscp_drive u_drive (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (drv_cmd),
        .o_speed_right (o_res.speed_right),
        .o_speed_left  (o_res.speed_left),
        .o_mode        (o_res.auto_mode),
        .o_stopped     (o_res.stopped)
    );

    assign o_res.valid     = r_out_valid;
    assign o_res.event_res = r_event;

    a_pos_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pos <= POS_W'(FRAME_LIMIT + 1))
        else $error("frame position past overflow mark");

    a_tok_open: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_tok |-> (r_tok != 3'd0))
        else $error("token open without a token count");

    a_accept_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> r_out_valid)
        else $error("accepted item left no result");

    a_frame_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && (n_event == EV_ECHO || n_event == EV_STATUS || n_event == EV_SET_MOTOR
                    || n_event == EV_SET_AUTO || n_event == EV_UNKNOWN
                    || n_event == EV_BINARY)) |=> (r_pos == '0))
        else $error("frame not closed after dispatch");

    a_key_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && op != OP_NONE && op != OP_SET_MOTOR && op != OP_SET_AUTO)
        |-> (r_pos == '0))
        else $error("single key acted inside a frame");

endmodule

@@ src/rscp_drive.sv @@
module rscp_drive (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  rscp_pkg::t_drive_cmd             i_cmd,
    output logic signed [rscp_pkg::SPD_W-1:0] o_speed_right,
    output logic signed [rscp_pkg::SPD_W-1:0] o_speed_left,
    output logic signed [rscp_pkg::SPD_W-1:0] o_mode,
    output logic                             o_stopped
);
    import rscp_pkg::*;

    localparam logic signed [SPD_W-1:0] STEP     = 16'sd25;
    localparam logic signed [SPD_W-1:0] STEP_LIM = 16'sd231;
    localparam logic signed [SPD_W-1:0] SPD_MAX  = 16'sd255;
    localparam logic signed [SPD_W-1:0] MODE_ON  = 16'sd1;
    localparam logic signed [SPD_W-1:0] MODE_OFF = 16'sd0;
    localparam logic signed [SPD_W-1:0] MODE_DEAD = -16'sd1;

    logic signed [SPD_W-1:0] r_right, n_right;
    logic signed [SPD_W-1:0] r_left, n_left;
    logic signed [SPD_W-1:0] r_mode, n_mode;
    logic                    r_stop, n_stop;
    logic signed [SPD_W-1:0] eq_right, eq_left;

    // stepping starts from equal sides when one of them is zero
    always_comb begin
        eq_right = r_right;
        eq_left  = r_left;
        if (r_left == '0) begin
            eq_left = r_right;
        end else if (r_right == '0) begin
            eq_right = r_left;
        end
    end

    always_comb begin
        n_right = r_right;
        n_left  = r_left;
        n_mode  = r_mode;
        n_stop  = r_stop;
        unique case (i_cmd.op)
            OP_KILL: begin
                n_mode  = MODE_DEAD;
                n_stop  = 1'b1;
                n_right = '0;
                n_left  = '0;
            end
            OP_STOP: begin
                n_stop = !r_stop;
            end
            OP_FWD: begin
                n_right = (eq_right < STEP_LIM) ? eq_right + STEP : SPD_MAX;
                n_left  = (eq_left < STEP_LIM) ? eq_left + STEP : SPD_MAX;
            end
            OP_BACK: begin
                n_right = (eq_right > -STEP_LIM) ? eq_right - STEP : -SPD_MAX;
                n_left  = (eq_left > -STEP_LIM) ? eq_left - STEP : -SPD_MAX;
            end
            OP_LEFT: begin
                n_left = '0;
            end
            OP_RIGHT: begin
                n_right = '0;
            end
            OP_SET_MOTOR: begin
                if (i_cmd.present[0]) n_right = i_cmd.right;
                if (i_cmd.present[1]) n_left  = i_cmd.left;
                if (i_cmd.present[2]) n_mode  = i_cmd.mode;
            end
            OP_SET_AUTO: begin
                if (i_cmd.present[0]) n_right = i_cmd.right;
                if (i_cmd.present[1]) n_left  = i_cmd.left;
                n_mode = (r_mode == MODE_ON) ? MODE_OFF : MODE_ON;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_right <= '0;
            r_left  <= '0;
            r_mode  <= '0;
            r_stop  <= 1'b0;
        end else begin
            r_right <= n_right;
            r_left  <= n_left;
            r_mode  <= n_mode;
            r_stop  <= n_stop;
        end
    end

    assign o_speed_right = r_right;
    assign o_speed_left  = r_left;
    assign o_mode        = r_mode;
    assign o_stopped     = r_stop;

endmodule
